/* rtl/lfu_pkg.sv */
package lfu_pkg;

	localparam int unsigned KEY_W = 32;
	localparam int unsigned VAL_W = 32;
	localparam int unsigned CNT_W = 32;
	localparam int unsigned STP_W = 32;
	localparam int unsigned CAP_W = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
	localparam logic KIND_GET = 1'b0;
	localparam logic KIND_PUT = 1'b1;
	localparam logic signed [VAL_W-1:0] MISS_VALUE = -VAL_W'(1);
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef struct packed {
		logic                    kind;
		logic signed [KEY_W-1:0] key;
		logic signed [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic                    found;
		logic signed [VAL_W-1:0] read_value;
		logic                    evicted;
		logic signed [KEY_W-1:0] evicted_key;
	} rsp_t;

	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [CNT_W-1:0] cnt;
		logic [STP_W-1:0] stp;
	} ent_t;

	typedef struct packed {
		logic hit;
		logic better;
	} cmp_t;

endpackage

/* rtl/lfu_cmp.sv */
module lfu_cmp (
	input  lfu_pkg::ent_t                cand,
	input  lfu_pkg::ent_t                best,
	input  logic [lfu_pkg::KEY_W-1:0]    key,
	output lfu_pkg::cmp_t                res
);

	logic cnt_lt;
	logic cnt_eq;
	logic stp_lt;

	assign cnt_lt = cand.cnt < best.cnt;
	assign cnt_eq = cand.cnt == best.cnt;
	assign stp_lt = cand.stp < best.stp;

	assign res.hit    = cand.valid && (cand.key == key);
	assign res.better = cand.valid && (!best.valid || cnt_lt || (cnt_eq && stp_lt));

endmodule

/* rtl/lfu_cache_table.sv */
// done rises once per request, after the scan and update states, with one response word per request
// a new request is taken only once the block is idle again; the scan is single-entry, through
//   the key, value, count and stamp memories, one entry read per cycle
// busy is high from the accepted start until the done cycle; results cannot be stalled
// reset clears valid bits, occupancy, order tick and sets capacity to 16
module lfu_cache_table #(
	parameter int unsigned ENTRIES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  lfu_pkg::req_t                 req,
	output logic                          done,
	output lfu_pkg::rsp_t                 rsp,
	input  logic                          cfg_we,
	input  logic [lfu_pkg::CAP_W-1:0]     cfg_wdata
);

	localparam int unsigned IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned OW   = $clog2(ENTRIES + 1);
	localparam int unsigned CMPW = (OW > lfu_pkg::CAP_W) ? OW : lfu_pkg::CAP_W;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_UPD  = 3'b100
	} state_t;

	state_t state_q;

	logic [lfu_pkg::CAP_W-1:0] capacity_q;
	logic [OW-1:0]             occ_q;
	logic [lfu_pkg::STP_W-1:0] tick_q;
	logic [ENTRIES-1:0]        valid_q;
	lfu_pkg::req_t             req_q;

	logic [lfu_pkg::KEY_W-1:0] key_mem [ENTRIES];
	logic [lfu_pkg::VAL_W-1:0] val_mem [ENTRIES];
	logic [lfu_pkg::CNT_W-1:0] cnt_mem [ENTRIES];
	logic [lfu_pkg::STP_W-1:0] stp_mem [ENTRIES];

	logic [IW:0]   issue_q;
	logic [IW-1:0] rd_addr;
	logic          rd_en;

	logic                      rd_vld_s1;
	logic [IW-1:0]             rd_idx_s1;
	lfu_pkg::ent_t             cand_s1;
	logic [lfu_pkg::VAL_W-1:0] val_s1;

	logic                      hit_q;
	logic [IW-1:0]             hit_idx_q;
	logic [lfu_pkg::VAL_W-1:0] hit_val_q;
	logic [lfu_pkg::CNT_W-1:0] hit_cnt_q;
	logic                      free_q;
	logic [IW-1:0]             free_idx_q;
	lfu_pkg::ent_t             best_q;
	logic [IW-1:0]             best_idx_q;

	lfu_pkg::cmp_t cmp_res;

	logic [CMPW-1:0] cap_w;
	logic [CMPW-1:0] cap_eff;
	logic [CMPW-1:0] occ_w;

	logic                      wr_key_en;
	logic                      wr_val_en;
	logic                      wr_cnt_en;
	logic                      wr_stp_en;
	logic [IW-1:0]             wr_addr;
	logic [lfu_pkg::CNT_W-1:0] wr_cnt;
	logic                      set_valid;
	logic                      occ_inc;
	logic                      tick_inc;
	lfu_pkg::rsp_t             rsp_d;

	logic                      done_q;
	lfu_pkg::rsp_t             rsp_q;

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	assign rd_addr = issue_q[IW-1:0];
	assign rd_en   = (state_q == ST_SCAN) && (issue_q < (IW+1)'(ENTRIES));

	assign cap_w   = CMPW'(capacity_q);
	assign cap_eff = (cap_w > CMPW'(ENTRIES)) ? CMPW'(ENTRIES) : cap_w;
	assign occ_w   = CMPW'(occ_q);

	lfu_cmp u_cmp (
		.cand (cand_s1),
		.best (best_q),
		.key  (req_q.key),
		.res  (cmp_res)
	);

	// update decision
	always_comb begin
		wr_key_en = 1'b0;
		wr_val_en = 1'b0;
		wr_cnt_en = 1'b0;
		wr_stp_en = 1'b0;
		wr_addr   = hit_idx_q;
		wr_cnt    = (hit_cnt_q == lfu_pkg::CNT_MAX) ? hit_cnt_q : hit_cnt_q + lfu_pkg::CNT_ONE;
		set_valid = 1'b0;
		occ_inc   = 1'b0;
		tick_inc  = 1'b0;
		rsp_d     = '0;
		rsp_d.found = hit_q;
		if (req_q.kind == lfu_pkg::KIND_GET) begin
			if (hit_q) begin
				rsp_d.read_value = hit_val_q;
				wr_cnt_en = 1'b1;
				wr_stp_en = 1'b1;
				tick_inc  = 1'b1;
			end else begin
				rsp_d.read_value = lfu_pkg::MISS_VALUE;
			end
		end else if (cap_eff != '0) begin
			if (hit_q) begin
				wr_val_en = 1'b1;
				wr_cnt_en = 1'b1;
				wr_stp_en = 1'b1;
				tick_inc  = 1'b1;
			end else if ((occ_w < cap_eff) && free_q) begin
				wr_addr   = free_idx_q;
				wr_cnt    = lfu_pkg::CNT_ONE;
				wr_key_en = 1'b1;
				wr_val_en = 1'b1;
				wr_cnt_en = 1'b1;
				wr_stp_en = 1'b1;
				set_valid = 1'b1;
				occ_inc   = 1'b1;
				tick_inc  = 1'b1;
			end else if (best_q.valid) begin
				wr_addr   = best_idx_q;
				wr_cnt    = lfu_pkg::CNT_ONE;
				wr_key_en = 1'b1;
				wr_val_en = 1'b1;
				wr_cnt_en = 1'b1;
				wr_stp_en = 1'b1;
				set_valid = 1'b1;
				tick_inc  = 1'b1;
				rsp_d.evicted     = 1'b1;
				rsp_d.evicted_key = best_q.key;
			end
		end
	end

	// memories
	always_ff @(posedge clk) begin
		if (rd_en) begin
			cand_s1.valid <= valid_q[rd_addr];
			cand_s1.key   <= key_mem[rd_addr];
			cand_s1.cnt   <= cnt_mem[rd_addr];
			cand_s1.stp   <= stp_mem[rd_addr];
			val_s1        <= val_mem[rd_addr];
		end
		if (state_q == ST_UPD) begin
			if (wr_key_en) begin
				key_mem[wr_addr] <= req_q.key;
			end
			if (wr_val_en) begin
				val_mem[wr_addr] <= req_q.value;
			end
			if (wr_cnt_en) begin
				cnt_mem[wr_addr] <= wr_cnt;
			end
			if (wr_stp_en) begin
				stp_mem[wr_addr] <= tick_q;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_q        <= req;
			best_q.valid <= 1'b0;
		end
		if (rd_en) begin
			rd_idx_s1 <= rd_addr;
		end
		if (rd_vld_s1) begin
			if (cmp_res.hit && !hit_q) begin
				hit_idx_q <= rd_idx_s1;
				hit_val_q <= val_s1;
				hit_cnt_q <= cand_s1.cnt;
			end
			if (!cand_s1.valid && !free_q) begin
				free_idx_q <= rd_idx_s1;
			end
			if (cmp_res.better) begin
				best_q.valid <= 1'b1;
				best_q.key   <= cand_s1.key;
				best_q.cnt   <= cand_s1.cnt;
				best_q.stp   <= cand_s1.stp;
				best_idx_q   <= rd_idx_s1;
			end
		end
		if (state_q == ST_UPD) begin
			rsp_q <= rsp_d;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			capacity_q   <= lfu_pkg::CAP_RESET;
			occ_q        <= '0;
			tick_q       <= '0;
			valid_q      <= '0;
			issue_q      <= '0;
			rd_vld_s1    <= 1'b0;
			hit_q        <= 1'b0;
			free_q       <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			done_q    <= 1'b0;
			rd_vld_s1 <= rd_en;
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						issue_q      <= '0;
						hit_q        <= 1'b0;
						free_q       <= 1'b0;
						state_q      <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						issue_q <= issue_q + (IW+1)'(1);
					end
					if (rd_vld_s1) begin
						if (cmp_res.hit) begin
							hit_q <= 1'b1;
						end
						if (!cand_s1.valid) begin
							free_q <= 1'b1;
						end
						if (rd_idx_s1 == IW'(ENTRIES - 1)) begin
							state_q <= ST_UPD;
						end
					end
				end
				ST_UPD: begin
					if (set_valid) begin
						valid_q[wr_addr] <= 1'b1;
					end
					if (occ_inc) begin
						occ_q <= occ_q + OW'(1);
					end
					if (tick_inc) begin
						tick_q <= tick_q + lfu_pkg::STP_W'(1);
					end
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
